/* hw/rtl/matrix3x3_inverse_defines.svh */
// Assertion macros for the 3x3 matrix inverse block.
`ifndef MATRIX3X3_INVERSE_DEFINES_SVH
`define MATRIX3X3_INVERSE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked property, ignored while reset is high.
`define MI3_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property, also active during reset.
`define MI3_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MI3_ASSERT(label, prop, msg)
`define MI3_ASSERT_RST(label, prop, msg)
`endif

`endif

/* hw/rtl/mi3_pkg.sv */
// Shared types and cofactor operand tables for the 3x3 matrix inverse.
package mi3_pkg;

  localparam int unsigned N_ENT = 9;
  localparam int unsigned N_DIM = 3;

  // Cofactor k = a[PA0[k]]*a[PA1[k]] - a[PB0[k]]*a[PB1[k]], entries row-major.
  localparam int unsigned PA0 [N_ENT] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int unsigned PA1 [N_ENT] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int unsigned PB0 [N_ENT] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int unsigned PB1 [N_ENT] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  typedef struct packed {
    logic overflow;
    logic singular;
  } mi3_flags_t;

endpackage

/* hw/rtl/matrix3x3_inverse.sv */
// Pipeline from request to result:
//   2 cofactor stages, 2 determinant stages, 2 divider prep stages,
//   OUT_WIDTH + 1 quotient-bit stages and one output register.
// Throughput: one request per cycle; every stage holds when the next is full,
//   and bubbles close up under back-pressure.
// Reset (rst, synchronous, active high) clears the valid bits only.
`include "matrix3x3_inverse_defines.svh"

module matrix3x3_inverse import mi3_pkg::*; #(
  parameter int unsigned IN_WIDTH  = 16,
  parameter int unsigned OUT_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 (signed, IN_WIDTH each), zero pad
  input  logic [((N_ENT*IN_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22 (signed, OUT_WIDTH each), zero pad
  output logic [((N_ENT*OUT_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
  // singular, overflow
  output logic [1:0]                             m_axis_tuser
);

  localparam int unsigned CW    = 2 * IN_WIDTH + 1;   // cofactor width
  localparam int unsigned DW    = 3 * IN_WIDTH + 3;   // determinant width
  localparam int unsigned TDO_W = ((N_ENT * OUT_WIDTH + 7) / 8) * 8;

  // cofactor -> determinant
  logic                      cof_valid, cof_ready;
  logic [N_ENT*CW-1:0]       cof_cof;
  logic [N_DIM*IN_WIDTH-1:0] cof_row0;

  // determinant -> divider
  logic                      det_valid, det_ready;
  logic [N_ENT*CW-1:0]       det_cof;
  logic [DW-1:0]             det_det;

  logic [N_ENT*OUT_WIDTH-1:0] res_data;
  mi3_flags_t                 res_flags;

  mi3_cofactor #(.IW(IN_WIDTH)) u_cof (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_mat   (s_axis_tdata[N_ENT*IN_WIDTH-1:0]),
    .out_valid(cof_valid),
    .out_ready(cof_ready),
    .out_cof  (cof_cof),
    .out_row0 (cof_row0)
  );

  mi3_det #(.IW(IN_WIDTH)) u_det (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cof_valid),
    .in_ready (cof_ready),
    .in_cof   (cof_cof),
    .in_row0  (cof_row0),
    .out_valid(det_valid),
    .out_ready(det_ready),
    .out_cof  (det_cof),
    .out_det  (det_det)
  );

  // divider's last stage is the output register
  mi3_div #(.IW(IN_WIDTH), .OW(OUT_WIDTH)) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (det_valid),
    .in_ready (det_ready),
    .in_cof   (det_cof),
    .in_det   (det_det),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (res_data),
    .out_flags(res_flags)
  );

  assign m_axis_tdata = TDO_W'(res_data);
  assign m_axis_tuser = res_flags;

  // singular results carry all-zero entries
  `MI3_ASSERT(a_singular_zero, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0, "singular result with nonzero entries")
  // singular and overflow are exclusive
  `MI3_ASSERT(a_flags_excl, m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]), "singular and overflow both set")
  // an empty output register lets the whole pipeline move
  `MI3_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output stage")
  // nothing valid right after reset
  `MI3_ASSERT_RST(a_reset_clear, rst |=> !m_axis_tvalid, "output valid after reset")

endmodule

/* hw/rtl/mi3_cofactor.sv */
// Two-stage adjugate cofactor unit: products, then differences.
module mi3_cofactor import mi3_pkg::*; #(
  parameter int unsigned IW = 16,
  localparam int unsigned CW = 2 * IW + 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [N_ENT*IW-1:0]   in_mat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [N_ENT*CW-1:0]   out_cof,
  output logic [N_DIM*IW-1:0]   out_row0
);

  logic                  v1, v2, adv1, adv2;
  logic signed [2*IW-1:0] pa [N_ENT];
  logic signed [2*IW-1:0] pb [N_ENT];
  logic [N_DIM*IW-1:0]   row0_1;

  assign adv2     = !v2 || out_ready;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;
  assign out_valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      for (int l = 0; l < N_ENT; l++) begin
        pa[l] <= $signed(in_mat[PA0[l]*IW +: IW]) * $signed(in_mat[PA1[l]*IW +: IW]);
        pb[l] <= $signed(in_mat[PB0[l]*IW +: IW]) * $signed(in_mat[PB1[l]*IW +: IW]);
      end
      row0_1 <= in_mat[N_DIM*IW-1:0];
    end
    if (adv2) begin
      for (int l = 0; l < N_ENT; l++) begin
        out_cof[l*CW +: CW] <= {pa[l][2*IW-1], pa[l]} - {pb[l][2*IW-1], pb[l]};
      end
      out_row0 <= row0_1;
    end
  end

endmodule

/* hw/rtl/mi3_det.sv */
// Two-stage determinant unit: first row times first cofactor column, then sum.
module mi3_det import mi3_pkg::*; #(
  parameter int unsigned IW = 16,
  localparam int unsigned CW = 2 * IW + 1,
  localparam int unsigned DW = 3 * IW + 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [N_ENT*CW-1:0]   in_cof,
  input  logic [N_DIM*IW-1:0]   in_row0,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [N_ENT*CW-1:0]   out_cof,
  output logic [DW-1:0]         out_det
);

  localparam int unsigned PW = IW + CW;

  logic                 v1, v2, adv1, adv2;
  logic signed [PW-1:0] q [N_DIM];
  logic [N_ENT*CW-1:0]  cof_1;

  assign adv2      = !v2 || out_ready;
  assign adv1      = !v1 || adv2;
  assign in_ready  = adv1;
  assign out_valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      // cofactors B00, B10, B20 sit at entries 0, 3, 6
      for (int j = 0; j < N_DIM; j++) begin
        q[j] <= $signed(in_row0[j*IW +: IW]) * $signed(in_cof[j*N_DIM*CW +: CW]);
      end
      cof_1 <= in_cof;
    end
    if (adv2) begin
      out_det <= {{2{q[0][PW-1]}}, q[0]} + {{2{q[1][PW-1]}}, q[1]}
               + {{2{q[2][PW-1]}}, q[2]};
      out_cof <= cof_1;
    end
  end

endmodule

/* hw/rtl/mi3_div.sv */
// Pipelined restoring divider: nine lanes share one determinant, one quotient bit per stage.
module mi3_div import mi3_pkg::*; #(
  parameter int unsigned IW = 16,
  parameter int unsigned OW = 32,
  localparam int unsigned CW = 2 * IW + 1,
  localparam int unsigned DW = 3 * IW + 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [N_ENT*CW-1:0]   in_cof,
  input  logic [DW-1:0]         in_det,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [N_ENT*OW-1:0]   out_data,
  output mi3_flags_t            out_flags
);

  localparam int unsigned SHIFT = IW / 2 + OW / 2;
  localparam int unsigned RW    = DW + OW + 2;
  localparam logic [OW:0] LIM    = (OW + 1)'(1) << (OW - 1);
  localparam logic [OW:0] LIM_M1 = LIM - 1'b1;

  // prep stage 1: magnitudes and signs
  logic             v_p1, adv_p1;
  logic [DW-1:0]    dmag_p1;
  logic             dneg_p1, zero_p1;
  logic [CW-1:0]    n_p1 [N_ENT];
  logic [N_ENT-1:0] cneg_p1;

  // prep stage 2: numerator and range check
  logic             v_p2, adv_p2;
  logic [DW-1:0]    dmag_p2;
  logic             zero_p2;
  logic [RW-1:0]    rem_p2 [N_ENT];
  logic [N_ENT-1:0] big_p2, neg_p2;

  // quotient stages, one per bit from OW down to 0
  wire  [OW:0]      v_d, adv_d, zero_d;
  wire  [DW-1:0]    dmag_d [OW+1];
  wire  [RW-1:0]    rem_d  [OW+1][N_ENT];
  wire  [OW:0]      q_d    [OW+1][N_ENT];
  wire  [N_ENT-1:0] big_d  [OW+1];
  wire  [N_ENT-1:0] neg_d  [OW+1];

  logic             v_o, adv_o;
  logic [OW-1:0]    res_c [N_ENT];
  logic             ovf_c;

  assign adv_o     = !v_o || out_ready;
  assign adv_p2    = !v_p2 || adv_d[0];
  assign adv_p1    = !v_p1 || adv_p2;
  assign in_ready  = adv_p1;
  assign out_valid = v_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p1 <= 1'b0;
      v_p2 <= 1'b0;
      v_o  <= 1'b0;
    end else begin
      if (adv_p1) v_p1 <= in_valid;
      if (adv_p2) v_p2 <= v_p1;
      if (adv_o)  v_o  <= v_d[OW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_p1) begin
      dneg_p1 <= in_det[DW-1];
      dmag_p1 <= in_det[DW-1] ? (~in_det + 1'b1) : in_det;
      zero_p1 <= (in_det == '0);
      for (int l = 0; l < N_ENT; l++) begin
        cneg_p1[l] <= in_cof[l*CW + CW - 1];
        n_p1[l]    <= in_cof[l*CW + CW - 1] ? (~in_cof[l*CW +: CW] + 1'b1)
                                             : in_cof[l*CW +: CW];
      end
    end
    if (adv_p2) begin
      dmag_p2 <= dmag_p1;
      zero_p2 <= zero_p1;
      for (int l = 0; l < N_ENT; l++) begin
        rem_p2[l] <= RW'(n_p1[l]) << SHIFT;
        big_p2[l] <= (RW'(n_p1[l]) << SHIFT) >= (RW'(dmag_p1) << (OW + 1));
        neg_p2[l] <= cneg_p1[l] ^ dneg_p1;
      end
    end
  end

  for (genvar s = 0; s <= OW; s++) begin : g_st
    localparam int unsigned K = OW - s;

    logic             v_src, zero_src;
    logic [DW-1:0]    dmag_src;
    logic [RW-1:0]    rem_src [N_ENT];
    logic [OW:0]      q_src [N_ENT];
    logic [N_ENT-1:0] big_src, neg_src;
    logic [RW-1:0]    trial;

    logic             v_q, zero_q;
    logic [DW-1:0]    dmag_q;
    logic [RW-1:0]    rem_q [N_ENT];
    logic [OW:0]      q_q [N_ENT];
    logic [N_ENT-1:0] big_q, neg_q;

    if (s == 0) begin : g_first
      always_comb begin
        v_src    = v_p2;
        zero_src = zero_p2;
        dmag_src = dmag_p2;
        big_src  = big_p2;
        neg_src  = neg_p2;
        for (int l = 0; l < N_ENT; l++) begin
          rem_src[l] = rem_p2[l];
          q_src[l]   = '0;
        end
      end
    end else begin : g_rest
      always_comb begin
        v_src    = v_d[s-1];
        zero_src = zero_d[s-1];
        dmag_src = dmag_d[s-1];
        big_src  = big_d[s-1];
        neg_src  = neg_d[s-1];
        for (int l = 0; l < N_ENT; l++) begin
          rem_src[l] = rem_d[s-1][l];
          q_src[l]   = q_d[s-1][l];
        end
      end
    end

    if (s == OW) begin : g_last
      assign adv_d[s] = !v_q || adv_o;
    end else begin : g_mid
      assign adv_d[s] = !v_q || adv_d[s+1];
    end

    assign trial = RW'(dmag_src) << K;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q <= 1'b0;
      end else if (adv_d[s]) begin
        v_q <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (adv_d[s]) begin
        dmag_q <= dmag_src;
        zero_q <= zero_src;
        big_q  <= big_src;
        neg_q  <= neg_src;
        for (int l = 0; l < N_ENT; l++) begin
          if (rem_src[l] >= trial) begin
            rem_q[l] <= rem_src[l] - trial;
            q_q[l]   <= {q_src[l][OW-1:0], 1'b1};
          end else begin
            rem_q[l] <= rem_src[l];
            q_q[l]   <= {q_src[l][OW-1:0], 1'b0};
          end
        end
      end
    end

    assign v_d[s]    = v_q;
    assign zero_d[s] = zero_q;
    assign dmag_d[s] = dmag_q;
    assign big_d[s]  = big_q;
    assign neg_d[s]  = neg_q;
    for (genvar l = 0; l < N_ENT; l++) begin : g_ln
      assign rem_d[s][l] = rem_q[l];
      assign q_d[s][l]   = q_q[l];
    end
  end

  // sign, saturation and singular override
  always_comb begin
    logic [OW:0] qf;
    logic [OW:0] nq;
    ovf_c = 1'b0;
    for (int l = 0; l < N_ENT; l++) begin
      qf = q_d[OW][l];
      nq = ~qf + 1'b1;
      if (zero_d[OW]) begin
        res_c[l] = '0;
      end else if (neg_d[OW][l]) begin
        if (big_d[OW][l] || (qf > LIM)) begin
          res_c[l] = LIM[OW-1:0];
          ovf_c    = 1'b1;
        end else begin
          res_c[l] = nq[OW-1:0];
        end
      end else begin
        if (big_d[OW][l] || (qf > LIM_M1)) begin
          res_c[l] = LIM_M1[OW-1:0];
          ovf_c    = 1'b1;
        end else begin
          res_c[l] = qf[OW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_o) begin
      for (int l = 0; l < N_ENT; l++) begin
        out_data[l*OW +: OW] <= res_c[l];
      end
      out_flags.singular <= zero_d[OW];
      out_flags.overflow <= ovf_c && !zero_d[OW];
    end
  end

endmodule

/* bench/matrix3x3_inverse_tb.sv */
// Self-checking bench for the pipelined 3x3 fixed-point matrix inverse.
`timescale 1ns / 1ps

module matrix3x3_inverse_tb import mi3_pkg::*; ();

  localparam int unsigned IW = 16;
  localparam int unsigned OW = 32;
  localparam int unsigned FRAC_SHIFT = IW / 2 + OW / 2;
  localparam int unsigned LATENCY = OW + 8;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // Matrix source flavors for the random part
  typedef enum int {
    SRC_FULL, SRC_SMALL, SRC_SINGULAR, SRC_TINY_DET
  } mat_src_t;

  typedef struct {
    logic [N_ENT*IW-1:0] data;
  } mat_req_t;

  typedef struct {
    logic [N_ENT*OW-1:0] data;
    logic [1:0]          user;
  } inv_rsp_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 (signed 16 bits each)
  logic [N_ENT*IW-1:0]   s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // r00, r01, r02, r10, r11, r12, r20, r21, r22 (signed 32 bits each)
  logic [N_ENT*OW-1:0]   m_axis_tdata;
  // singular, overflow
  logic [1:0]            m_axis_tuser;

  mat_req_t pending_mats[$];
  inv_rsp_t expected_invs[$];

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_seq = 0;
  int  hold_seen = 0;
  int  hold_cnt = 0;
  int  cycle_cnt = 0;
  int  fail_cnt = 0;
  logic in_fire = 1'b0;

  matrix3x3_inverse #(.IN_WIDTH(IW), .OUT_WIDTH(OW)) u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always #2 clk = ~clk;

  // Adjugate over determinant; every product is exact in 64 bits at these
  // widths, so only the final quotient truncates toward zero.
  function automatic inv_rsp_t invert_matrix(logic [N_ENT*IW-1:0] packed_m);
    longint a[9];
    longint cof[9];
    longint det;
    longint unsigned dmag, nmag, quo;
    longint unsigned lim;
    logic neg, ovf;
    inv_rsp_t rsp;
    lim = 64'd1 << (OW - 1);
    ovf = 1'b0;
    for (int k = 0; k < 9; k++) a[k] = longint'($signed(packed_m[IW*k +: IW]));
    cof[0] = a[4]*a[8] - a[5]*a[7];
    cof[1] = a[2]*a[7] - a[1]*a[8];
    cof[2] = a[1]*a[5] - a[2]*a[4];
    cof[3] = a[5]*a[6] - a[3]*a[8];
    cof[4] = a[0]*a[8] - a[2]*a[6];
    cof[5] = a[2]*a[3] - a[0]*a[5];
    cof[6] = a[3]*a[7] - a[4]*a[6];
    cof[7] = a[1]*a[6] - a[0]*a[7];
    cof[8] = a[0]*a[4] - a[1]*a[3];
    det = a[0]*cof[0] + a[1]*cof[3] + a[2]*cof[6];
    rsp.data = '0;
    if (det == 0) begin
      rsp.user = 2'b01;
      return rsp;
    end
    dmag = (det < 0) ? longint'(-det) : longint'(det);
    for (int k = 0; k < 9; k++) begin
      nmag = (cof[k] < 0) ? longint'(-cof[k]) : longint'(cof[k]);
      quo = (nmag << FRAC_SHIFT) / dmag;
      neg = (cof[k] < 0) != (det < 0);
      if (nmag == 0) begin
        quo = 0;
      end else if (neg) begin
        if (quo > lim) begin
          quo = lim;
          ovf = 1'b1;
        end
        quo = -quo;
      end else if (quo > lim - 1) begin
        quo = lim - 1;
        ovf = 1'b1;
      end
      rsp.data[OW*k +: OW] = quo[OW-1:0];
    end
    rsp.user = {ovf, 1'b0};
    return rsp;
  endfunction

  // Random matrix of a given flavor
  function automatic logic [N_ENT*IW-1:0] random_matrix(mat_src_t src);
    logic [N_ENT*IW-1:0] m;
    for (int k = 0; k < 9; k++) begin
      case (src)
        SRC_FULL:     m[IW*k +: IW] = IW'($urandom);
        SRC_SMALL:    m[IW*k +: IW] = IW'($urandom_range(1024) - 512);
        SRC_SINGULAR: m[IW*k +: IW] = IW'($urandom);
        default: begin
          // near-zero entries give a tiny determinant and a huge inverse
          m[IW*k +: IW] = (k % 4 == 0) ? IW'($urandom_range(8) - 4)
                                       : IW'($urandom_range(2) - 1);
        end
      endcase
    end
    // singular: row 2 copies row 0 (or is zero)
    if (src == SRC_SINGULAR)
      m[6*IW +: 3*IW] = $urandom_range(1) ? m[0 +: 3*IW] : '0;
    return m;
  endfunction

  function automatic logic [N_ENT*IW-1:0] pack9(int v0, int v1, int v2, int v3,
      int v4, int v5, int v6, int v7, int v8);
    return {IW'(v8), IW'(v7), IW'(v6), IW'(v5), IW'(v4), IW'(v3), IW'(v2),
            IW'(v1), IW'(v0)};
  endfunction

  // Input request handshake and prediction; output check
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      in_fire <= !rst && s_axis_tvalid && s_axis_tready;
      if (!rst && s_axis_tvalid && s_axis_tready)
        expected_invs.push_back(invert_matrix(s_axis_tdata));
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        if (expected_invs.size() == 0) begin
          $error("result with no request outstanding");
          fail_cnt = fail_cnt + 1;
        end else begin
          inv_rsp_t want;
          want = expected_invs.pop_front();
          for (int k = 0; k < 9; k++)
            if (m_axis_tdata[OW*k +: OW] !== want.data[OW*k +: OW]) begin
              $error("r%0d%0d expected %0d actual %0d", k / 3, k % 3,
                     $signed(want.data[OW*k +: OW]),
                     $signed(m_axis_tdata[OW*k +: OW]));
              fail_cnt = fail_cnt + 1;
            end
          if (m_axis_tuser[0] !== want.user[0]) begin
            $error("singular expected %0d actual %0d", want.user[0], m_axis_tuser[0]);
            fail_cnt = fail_cnt + 1;
          end
          if (m_axis_tuser[1] !== want.user[1]) begin
            $error("overflow expected %0d actual %0d", want.user[1], m_axis_tuser[1]);
            fail_cnt = fail_cnt + 1;
          end
        end
      end
    end
  end

  // Sender: advance when the current request was taken or none is up
  always @(negedge clk) begin
    if (!rst && (!s_axis_tvalid || in_fire)) begin
      if (pending_mats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        mat_req_t req;
        req = pending_mats.pop_front();
        s_axis_tdata <= req.data;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus a single long hold-off
  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_cnt <= 300;
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !rst && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    mat_req_t req;
    int src_pick;
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: singular, identity, extremes, sign of det, overflow
    req.data = '0;                                                 pending_mats.push_back(req);
    req.data = pack9(256, 0, 0, 0, 256, 0, 0, 0, 256);             pending_mats.push_back(req);
    req.data = pack9(-256, 0, 0, 0, 256, 0, 0, 0, 256);            pending_mats.push_back(req);
    req.data = pack9(512, 0, 0, 0, -128, 0, 0, 0, 64);             pending_mats.push_back(req);
    req.data = pack9(32767, 0, 0, 0, 32767, 0, 0, 0, 32767);       pending_mats.push_back(req);
    req.data = pack9(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768);    pending_mats.push_back(req);
    req.data = pack9(1, 0, 0, 0, 1, 0, 0, 0, 1);                   pending_mats.push_back(req);
    req.data = pack9(-1, 0, 0, 0, 1, 0, 0, 0, 1);                  pending_mats.push_back(req);
    req.data = pack9(0, 256, 0, 256, 0, 0, 0, 0, 256);             pending_mats.push_back(req);
    req.data = pack9(-32768, 32767, -32768, 32767, -32768, 32767,
                     -1, 1, -32768);                               pending_mats.push_back(req);
    req.data = pack9(32767, 32767, 32767, 32767, 32767, 32767,
                     32767, 32767, 32767);                         pending_mats.push_back(req);
    req.data = '1;                                                 pending_mats.push_back(req);
    req.data = pack9(256, 512, 768, 1024, 1280, 1536, 1792, 2048, 2304);
    pending_mats.push_back(req);
    req.data = pack9(2, 1, 0, 1, 2, 1, 0, 1, 2);                   pending_mats.push_back(req);
    req.data = pack9(768, -256, 0, 128, 512, -64, 32, 16, 1024);   pending_mats.push_back(req);
    req.data = pack9(16384, 0, 0, 0, 16384, 0, 0, 0, 16384);       pending_mats.push_back(req);

    // Hold the output off while requests keep coming so the pipe fills
    hold_seq = hold_seq + 1;
    for (int k = 0; k < 80; k++) begin
      req.data = random_matrix(SRC_SMALL);
      pending_mats.push_back(req);
    end

    for (int phase = 0; phase < 4; phase++) begin
      // Sender pauses here until the pipe has drained completely
      while (pending_mats.size() != 0 || expected_invs.size() != 0) @(posedge clk);
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      for (int k = 0; k < 465; k++) begin
        src_pick = $urandom_range(99);
        if (src_pick < 30)      req.data = random_matrix(SRC_FULL);
        else if (src_pick < 75) req.data = random_matrix(SRC_SMALL);
        else if (src_pick < 87) req.data = random_matrix(SRC_SINGULAR);
        else                    req.data = random_matrix(SRC_TINY_DET);
        pending_mats.push_back(req);
        // let the queue drain to 40 entries before adding the rest
        if (k == 200) while (pending_mats.size() > 40) @(posedge clk);
      end
    end

    while (pending_mats.size() != 0 || s_axis_tvalid || expected_invs.size() != 0)
      @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (fail_cnt == 0 && expected_invs.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
